>>> rtl/double_array_trie_lookup_insert_top_defines.svh
// Assertion macros for the trie block.
`ifndef DOUBLE_ARRAY_TRIE_LOOKUP_INSERT_TOP_DEFINES_SVH
`define DOUBLE_ARRAY_TRIE_LOOKUP_INSERT_TOP_DEFINES_SVH

// Fire when a implies b on the next clock.
`define DAT_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

// Fire when a implies b on the same clock.
`define DAT_ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

`endif

>>> rtl/dat_pkg.sv
package dat_pkg;

  localparam int unsigned END_CODE    = 1;
  localparam int unsigned BYTE_OFFSET = 2;
  localparam int unsigned TOP_CODE    = 257;
  localparam int unsigned CODE_W      = 9;

  localparam logic [1:0] ST_PRESENT  = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic       mode;
    logic [7:0] symbol;
    logic       key_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] end_slot;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_BASE,
    S_RD_CHILD,
    S_DECIDE,
    S_CLAIM,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SRCH_INIT,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_MV_INIT,
    S_MV_RD_OLD,
    S_MV_RD_OLDB,
    S_MV_WR_NEW,
    S_MV_G_RD,
    S_MV_G_CHK,
    S_MV_FREE,
    S_MV_NODE,
    S_DONE,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic b_we;
    logic p_we;
  } mem_wr_t;

endpackage

>>> rtl/dat_store.sv
module dat_store import dat_pkg::*; #(
  parameter int unsigned SLOTS = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned BW    = 12,
  parameter int unsigned PW    = 13
) (
  input  logic          clk,
  input  logic [AW-1:0] b_raddr,
  output logic [BW-1:0] b_rdata,
  input  logic [AW-1:0] p_raddr,
  output logic [PW-1:0] p_rdata,
  input  mem_wr_t       wr,
  input  logic [AW-1:0] b_waddr,
  input  logic [BW-1:0] b_wdata,
  input  logic [AW-1:0] p_waddr,
  input  logic [PW-1:0] p_wdata
);

  logic [BW-1:0] base_mem [SLOTS];
  logic [PW-1:0] par_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.b_we) base_mem[b_waddr] <= b_wdata;
    b_rdata <= base_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.p_we) par_mem[p_waddr] <= p_wdata;
    p_rdata <= par_mem[p_raddr];
  end

endmodule

>>> rtl/dat_ctrl.sv
module dat_ctrl import dat_pkg::*; #(
  parameter int unsigned SLOTS = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned PW    = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_item_t      in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data,
  output logic [AW-1:0] b_raddr,
  input  logic [AW-1:0] b_rdata,
  output logic [AW-1:0] p_raddr,
  input  logic [PW-1:0] p_rdata,
  output mem_wr_t       wr,
  output logic [AW-1:0] b_waddr,
  output logic [AW-1:0] b_wdata,
  output logic [AW-1:0] p_waddr,
  output logic [PW-1:0] p_wdata
);

  localparam int unsigned SW = AW + 2;
  localparam logic [SW-1:0] SLOTS_W = SW'(SLOTS);

  fsm_t state_r, state_nxt;
  logic [AW-1:0] node_r, node_nxt;
  logic missed_r, missed_nxt, full_r, full_nxt;
  logic ins_r, ins_nxt, end_r, end_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [AW-1:0] nbase_r, nbase_nxt;
  logic [SW-1:0] t_r, t_nxt;
  logic [TOP_CODE:0] has_r, has_nxt;
  logic [CODE_W-1:0] c_r, c_nxt;
  logic [CODE_W-1:0] g_r, g_nxt;
  logic [SW-1:0] b_r, b_nxt;
  logic [AW-1:0] obase_r, obase_nxt;
  logic [AW-1:0] cbase_r, cbase_nxt;
  logic [1:0] st_r, st_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic ovalid_r, ovalid_nxt;
  out_item_t odata_r, odata_nxt;

  logic [SW-1:0] node_p1, o_sum, n_sum, x_sum;
  logic [SW-1:0] first_c;

  assign node_p1 = SW'(node_r) + SW'(1);
  assign o_sum   = SW'(obase_r) + SW'(c_r);
  assign n_sum   = b_r + SW'(c_r);
  assign x_sum   = SW'(cbase_r) + SW'(g_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      node_r   <= '0;
      missed_r <= 1'b0;
      full_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      node_r   <= node_nxt;
      missed_r <= missed_nxt;
      full_r   <= full_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r   <= ins_nxt;
    end_r   <= end_nxt;
    code_r  <= code_nxt;
    nbase_r <= nbase_nxt;
    t_r     <= t_nxt;
    has_r   <= has_nxt;
    c_r     <= c_nxt;
    g_r     <= g_nxt;
    b_r     <= b_nxt;
    obase_r <= obase_nxt;
    cbase_r <= cbase_nxt;
    st_r    <= st_nxt;
    slot_r  <= slot_nxt;
    odata_r <= odata_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_comb begin
    state_nxt  = state_r;
    node_nxt   = node_r;
    missed_nxt = missed_r;
    full_nxt   = full_r;
    ins_nxt    = ins_r;
    end_nxt    = end_r;
    code_nxt   = code_r;
    nbase_nxt  = nbase_r;
    t_nxt      = t_r;
    has_nxt    = has_r;
    c_nxt      = c_r;
    g_nxt      = g_r;
    b_nxt      = b_r;
    obase_nxt  = obase_r;
    cbase_nxt  = cbase_r;
    st_nxt     = st_r;
    slot_nxt   = slot_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    b_raddr    = node_r;
    p_raddr    = t_r[AW-1:0];
    wr         = '0;
    b_waddr    = t_r[AW-1:0];
    b_wdata    = '0;
    p_waddr    = t_r[AW-1:0];
    p_wdata    = '0;
    first_c    = '0;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ins_nxt  = in_data.mode;
          end_nxt  = in_data.key_end;
          code_nxt = in_data.key_end ? CODE_W'(END_CODE)
                                     : CODE_W'(in_data.symbol) + CODE_W'(BYTE_OFFSET);
          if (in_data.key_end && (full_r || missed_r)) begin
            st_nxt    = full_r ? ST_FULL : ST_NOTFOUND;
            slot_nxt  = '0;
            state_nxt = S_DONE;
          end else if (!in_data.key_end && (full_r || missed_r)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD_BASE;
          end
        end
      end
      S_RD_BASE: begin
        b_raddr   = node_r;
        state_nxt = S_RD_CHILD;
      end
      S_RD_CHILD: begin
        nbase_nxt = b_rdata;
        t_nxt     = SW'(b_rdata) + SW'(code_r);
        p_raddr   = b_rdata + AW'(code_r);
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (t_r < SLOTS_W && p_rdata == PW'(node_p1)) begin
          if (end_r) begin
            st_nxt    = ST_PRESENT;
            slot_nxt  = t_r[AW-1:0];
            state_nxt = S_DONE;
          end else begin
            node_nxt  = t_r[AW-1:0];
            state_nxt = S_IDLE;
          end
        end else if (!ins_r) begin
          if (end_r) begin
            st_nxt    = ST_NOTFOUND;
            slot_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            missed_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (t_r < SLOTS_W && p_rdata == '0) begin
          state_nxt = S_CLAIM;
        end else begin
          has_nxt   = '0;
          c_nxt     = CODE_W'(END_CODE);
          state_nxt = S_SCAN_RD;
        end
      end
      S_CLAIM: begin
        wr.p_we = 1'b1;
        wr.b_we = 1'b1;
        p_waddr = t_r[AW-1:0];
        p_wdata = PW'(node_p1);
        b_waddr = t_r[AW-1:0];
        b_wdata = '0;
        if (end_r) begin
          st_nxt    = ST_INSERTED;
          slot_nxt  = t_r[AW-1:0];
          state_nxt = S_DONE;
        end else begin
          node_nxt  = t_r[AW-1:0];
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        t_nxt     = SW'(nbase_r) + SW'(c_r);
        p_raddr   = nbase_r + AW'(c_r);
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (t_r < SLOTS_W && p_rdata == PW'(node_p1)) has_nxt[c_r] = 1'b1;
        if (c_r == CODE_W'(TOP_CODE)) begin
          has_nxt[code_r] = 1'b1;
          b_nxt     = '0;
          state_nxt = S_SRCH_INIT;
        end else begin
          c_nxt     = c_r + CODE_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_SRCH_INIT: begin
        c_nxt     = CODE_W'(END_CODE);
        state_nxt = S_SRCH_RD;
        if (b_r >= SLOTS_W) begin
          full_nxt = !end_r;
          if (end_r) begin
            st_nxt    = ST_FULL;
            slot_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SRCH_RD: begin
        if (!has_r[c_r]) begin
          if (c_r == CODE_W'(TOP_CODE)) begin
            obase_nxt = nbase_r;
            c_nxt     = CODE_W'(END_CODE);
            state_nxt = S_MV_INIT;
          end else begin
            c_nxt = c_r + CODE_W'(1);
          end
        end else if (n_sum >= SLOTS_W) begin
          b_nxt     = b_r + SW'(1);
          state_nxt = S_SRCH_INIT;
        end else begin
          p_raddr   = n_sum[AW-1:0];
          state_nxt = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        if (p_rdata != '0) begin
          b_nxt     = b_r + SW'(1);
          state_nxt = S_SRCH_INIT;
        end else if (c_r == CODE_W'(TOP_CODE)) begin
          obase_nxt = nbase_r;
          c_nxt     = CODE_W'(END_CODE);
          state_nxt = S_MV_INIT;
        end else begin
          c_nxt     = c_r + CODE_W'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_MV_INIT: begin
        has_nxt[code_r] = 1'b0;
        state_nxt = S_MV_RD_OLD;
      end
      S_MV_RD_OLD: begin
        if (!has_r[c_r]) begin
          if (c_r == CODE_W'(TOP_CODE)) state_nxt = S_MV_NODE;
          else c_nxt = c_r + CODE_W'(1);
        end else begin
          b_raddr   = o_sum[AW-1:0];
          state_nxt = S_MV_RD_OLDB;
        end
      end
      S_MV_RD_OLDB: begin
        cbase_nxt = b_rdata;
        state_nxt = S_MV_WR_NEW;
      end
      S_MV_WR_NEW: begin
        wr.b_we   = 1'b1;
        wr.p_we   = 1'b1;
        b_waddr   = n_sum[AW-1:0];
        b_wdata   = cbase_r;
        p_waddr   = n_sum[AW-1:0];
        p_wdata   = PW'(node_p1);
        g_nxt     = CODE_W'(END_CODE);
        state_nxt = S_MV_G_RD;
      end
      S_MV_G_RD: begin
        t_nxt     = x_sum;
        p_raddr   = x_sum[AW-1:0];
        state_nxt = S_MV_G_CHK;
      end
      S_MV_G_CHK: begin
        if (t_r < SLOTS_W && p_rdata == PW'(o_sum + SW'(1))) begin
          wr.p_we = 1'b1;
          p_waddr = t_r[AW-1:0];
          p_wdata = PW'(n_sum + SW'(1));
        end
        if (g_r == CODE_W'(TOP_CODE)) begin
          state_nxt = S_MV_FREE;
        end else begin
          g_nxt     = g_r + CODE_W'(1);
          state_nxt = S_MV_G_RD;
        end
      end
      S_MV_FREE: begin
        wr.b_we = 1'b1;
        wr.p_we = 1'b1;
        b_waddr = o_sum[AW-1:0];
        b_wdata = '0;
        p_waddr = o_sum[AW-1:0];
        p_wdata = '0;
        if (c_r == CODE_W'(TOP_CODE)) begin
          state_nxt = S_MV_NODE;
        end else begin
          c_nxt     = c_r + CODE_W'(1);
          state_nxt = S_MV_RD_OLD;
        end
      end
      S_MV_NODE: begin
        wr.b_we   = 1'b1;
        b_waddr   = node_r;
        b_wdata   = b_r[AW-1:0];
        first_c   = b_r + SW'(code_r);
        t_nxt     = first_c;
        state_nxt = S_CLAIM;
      end
      S_DONE: begin
        if (!ovalid_r || out_ready) begin
          odata_nxt.status   = st_r;
          odata_nxt.end_slot = 12'(slot_r);
          ovalid_nxt = 1'b1;
          node_nxt   = '0;
          missed_nxt = 1'b0;
          full_nxt   = 1'b0;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/dat_clear.sv
module dat_clear import dat_pkg::*; #(
  parameter int unsigned SLOTS = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          busy,
  output logic [AW-1:0] addr
);

  logic [AW:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (busy) cnt_nxt = cnt_r + (AW+1)'(1);
  end

  assign busy = cnt_r < (AW+1)'(SLOTS);
  assign addr = cnt_r[AW-1:0];

endmodule

>>> rtl/double_array_trie_lookup_insert_top.sv
// Channel | Direction | Payload
// in_     | in        | in_item_t   (mode, symbol, key_end)
// out_    | out       | out_item_t  (status, end_slot)
// A byte item found in the table steps through a base read, then a check read.
// An insert with relocation scans all codes, searches bases and moves each
// child with a sweep over its codes.
// After reset a clearing pass writes TABLE_SLOTS entries, one per cycle.
// One item is in work at a time; a waiting result holds only the next answer.
module double_array_trie_lookup_insert_top import dat_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam int unsigned PW = AW + 1;

  logic [AW-1:0] b_raddr, b_rdata, p_raddr, b_waddr, b_wdata, p_waddr;
  logic [AW-1:0] b_waddr_m, b_wdata_m, p_waddr_m, clr_addr;
  logic [PW-1:0] p_rdata, p_wdata, p_wdata_m;
  mem_wr_t wr, wr_m;
  logic clr_busy, ctl_ready;

  dat_clear #(.SLOTS(TABLE_SLOTS), .AW(AW)) u_clear (
    .clk(clk), .rst_n(rst_n), .busy(clr_busy), .addr(clr_addr)
  );

  dat_ctrl #(.SLOTS(TABLE_SLOTS), .AW(AW), .PW(PW)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid && !clr_busy), .in_ready(ctl_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .b_raddr(b_raddr), .b_rdata(b_rdata), .p_raddr(p_raddr), .p_rdata(p_rdata),
    .wr(wr), .b_waddr(b_waddr), .b_wdata(b_wdata),
    .p_waddr(p_waddr), .p_wdata(p_wdata)
  );

  assign in_ready  = ctl_ready && !clr_busy;
  assign wr_m      = clr_busy ? mem_wr_t'(2'b11) : wr;
  assign b_waddr_m = clr_busy ? clr_addr : b_waddr;
  assign p_waddr_m = clr_busy ? clr_addr : p_waddr;
  assign b_wdata_m = clr_busy ? '0 : b_wdata;
  assign p_wdata_m = clr_busy ? '0 : p_wdata;

  dat_store #(.SLOTS(TABLE_SLOTS), .AW(AW), .BW(AW), .PW(PW)) u_store (
    .clk(clk),
    .b_raddr(b_raddr), .b_rdata(b_rdata), .p_raddr(p_raddr), .p_rdata(p_rdata),
    .wr(wr_m), .b_waddr(b_waddr_m), .b_wdata(b_wdata_m),
    .p_waddr(p_waddr_m), .p_wdata(p_wdata_m)
  );

endmodule

>>> rtl/dat_checker.sv
`include "double_array_trie_lookup_insert_top_defines.svh"
module dat_checker import dat_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `DAT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `DAT_ASSERT_SAME(a_slot_zero, clk, rst_n, out_valid && (out_data.status == ST_NOTFOUND || out_data.status == ST_FULL), out_data.end_slot == 12'd0)
  `DAT_ASSERT_NEXT(a_byte_silent, clk, rst_n, in_valid && in_ready && !in_data.key_end && !out_valid, !out_valid)

endmodule

bind double_array_trie_lookup_insert_top dat_checker u_checker (.*);

>>> dv/double_array_trie_lookup_insert_top_tb.sv
module double_array_trie_lookup_insert_top_tb;
  import dat_pkg::*;

  localparam int unsigned SLOTS = 4096;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  double_array_trie_lookup_insert_top #(.TABLE_SLOTS(SLOTS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // trie shadow
  logic [11:0] trie_base [SLOTS];
  logic [12:0] trie_parent [SLOTS];
  int unsigned walk_node;
  bit walk_missed, walk_full;

  out_item_t lookup_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int inserted_seen = 0, full_seen = 0, notfound_seen = 0, present_seen = 0;
  longint cycles = 0;
  bit stall_hold = 1'b0;
  bit stim_done = 1'b0;

  function automatic bit child_of(int unsigned node, int unsigned code,
                                  output int unsigned slot);
    int unsigned t;
    t = trie_base[node] + code;
    slot = t;
    return (t < SLOTS) && (trie_parent[t] == node + 1);
  endfunction

  function automatic bit grow_edge(int unsigned node, int unsigned code,
                                   output int unsigned slot);
    bit has [TOP_CODE+1];
    int unsigned t, b, old_base, o, n, x, dummy;
    bit ok;
    ok = 1'b0;
    t = trie_base[node] + code;
    if (t < SLOTS && trie_parent[t] == 0) begin
      trie_parent[t] = 13'(node + 1);
      trie_base[t] = '0;
      slot = t;
      return 1'b1;
    end
    old_base = trie_base[node];
    for (int unsigned c = END_CODE; c <= TOP_CODE; c++) has[c] = child_of(node, c, dummy);
    has[code] = 1'b1;
    for (b = 0; b < SLOTS; b++) begin
      ok = 1'b1;
      for (int unsigned c = END_CODE; c <= TOP_CODE; c++) begin
        if (has[c] && (b + c >= SLOTS || trie_parent[b + c] != 0)) begin
          ok = 1'b0;
          break;
        end
      end
      if (ok) break;
    end
    if (!ok) return 1'b0;
    has[code] = 1'b0;
    for (int unsigned c = END_CODE; c <= TOP_CODE; c++) begin
      if (!has[c]) continue;
      o = old_base + c;
      n = b + c;
      trie_base[n] = trie_base[o];
      trie_parent[n] = 13'(node + 1);
      for (int unsigned g = END_CODE; g <= TOP_CODE; g++) begin
        x = trie_base[o] + g;
        if (x < SLOTS && trie_parent[x] == o + 1) trie_parent[x] = 13'(n + 1);
      end
      trie_parent[o] = '0;
      trie_base[o] = '0;
    end
    trie_base[node] = 12'(b);
    t = b + code;
    trie_parent[t] = 13'(node + 1);
    trie_base[t] = '0;
    slot = t;
    return 1'b1;
  endfunction

  task automatic walk_item(in_item_t it);
    int unsigned s, t, code;
    out_item_t r;
    s = walk_node;
    t = 0;
    code = it.symbol + BYTE_OFFSET;
    if (!it.key_end) begin
      if (walk_full || walk_missed) return;
      if (child_of(s, code, t)) walk_node = t;
      else if (it.mode) begin
        if (grow_edge(s, code, t)) walk_node = t;
        else walk_full = 1'b1;
      end else walk_missed = 1'b1;
      return;
    end
    r = '0;
    if (walk_full) r.status = ST_FULL;
    else if (walk_missed) r.status = ST_NOTFOUND;
    else if (child_of(s, END_CODE, t)) begin
      r.status = ST_PRESENT;
      r.end_slot = t[11:0];
    end else if (it.mode) begin
      if (grow_edge(s, END_CODE, t)) begin
        r.status = ST_INSERTED;
        r.end_slot = t[11:0];
      end else r.status = ST_FULL;
    end else r.status = ST_NOTFOUND;
    walk_node = 0;
    walk_missed = 1'b0;
    walk_full = 1'b0;
    lookup_results.push_back(r);
  endtask

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    walk_item(it);
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic in_item_t mk(bit m, logic [7:0] s, bit e);
    in_item_t it;
    it.mode = m;
    it.symbol = s;
    it.key_end = e;
    return it;
  endfunction

  // directed rows; check_fixed flags rows whose result is typed in
  typedef struct {
    in_item_t  item;
    bit        check_fixed;
    out_item_t fixed;
  } row_t;

  row_t rows [$];

  task automatic send_key(bit m, int unsigned len, logic [7:0] pool_hi);
    for (int unsigned i = 0; i < len; i++)
      send_item(mk(($urandom_range(0, 9) == 0) ? ~m : m,
                   8'($urandom_range(0, pool_hi)), 1'b0));
    send_item(mk(m, 8'($urandom), 1'b1));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (lookup_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", out_data);
      end else begin
        out_item_t e;
        e = lookup_results.pop_front();
        case (e.status)
          ST_PRESENT:  present_seen <= present_seen + 1;
          ST_NOTFOUND: notfound_seen <= notfound_seen + 1;
          ST_INSERTED: inserted_seen <= inserted_seen + 1;
          default:     full_seen <= full_seen + 1;
        endcase
        if (out_data.status !== e.status || out_data.end_slot !== e.end_slot) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                     e.status, e.end_slot, out_data.status, out_data.end_slot);
        end
      end
    end
  end

  initial begin
    int unsigned gap;
    @(negedge clk);
    while (!stim_done) begin
      if (stall_hold) begin
        out_ready <= 1'b0;
        @(negedge clk);
        continue;
      end
      gap = pick_gap();
      out_ready <= (gap == 0) || ($urandom_range(0, 1) == 1);
      @(negedge clk);
    end
    out_ready <= 1'b1;
  end

  initial begin
    out_item_t nf, f0;
    in_item_t  it;
    int unsigned idle;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      trie_base[i] = '0;
      trie_parent[i] = '0;
    end
    walk_node = 0;
    walk_missed = 1'b0;
    walk_full = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    nf.status = ST_NOTFOUND;
    nf.end_slot = '0;
    f0.status = ST_INSERTED;
    f0.end_slot = 12'd1;
    rows.push_back('{mk(1'b0, 8'h00, 1'b1), 1'b1, nf});
    rows.push_back('{mk(1'b0, 8'hff, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b1, 8'h00, 1'b1), 1'b1, nf});
    rows.push_back('{mk(1'b1, 8'h5a, 1'b1), 1'b1, f0});
    rows.push_back('{mk(1'b0, 8'h00, 1'b1), 1'b0, '0});
    rows.push_back('{mk(1'b1, 8'hff, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b1, 8'h00, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b1, 8'h00, 1'b1), 1'b0, '0});
    rows.push_back('{mk(1'b0, 8'hff, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b0, 8'h00, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b0, 8'h00, 1'b1), 1'b0, '0});
    rows.push_back('{mk(1'b1, 8'h00, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b1, 8'h01, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b1, 8'h00, 1'b1), 1'b0, '0});
    rows.push_back('{mk(1'b0, 8'h77, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b1, 8'h01, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b1, 8'h00, 1'b1), 1'b0, '0});
    rows.push_back('{mk(1'b1, 8'h80, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b0, 8'h7f, 1'b1), 1'b0, '0});
    rows.push_back('{mk(1'b0, 8'hff, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b0, 8'h00, 1'b1), 1'b0, '0});

    foreach (rows[i]) begin
      int unsigned pend;
      pend = lookup_results.size();
      send_item(rows[i].item);
      if (rows[i].check_fixed && lookup_results.size() > pend &&
          lookup_results[lookup_results.size()-1] != rows[i].fixed) begin
        mismatches = mismatches + 1;
        $display("directed row %0d: predictor disagrees with typed result", i);
      end
    end

    // hold the receiver off while keys keep streaming in
    stall_hold = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        stall_hold = 1'b0;
      end
      begin
        for (int k = 0; k < 12; k++) send_key(1'b1, $urandom_range(1, 3), 8'h0f);
      end
    join

    idle = 0;
    while (idle < RANDOM_ITEMS) begin
      int unsigned kind;
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        send_key($urandom_range(0, 2) != 0, $urandom_range(0, 4),
                 $urandom_range(0, 3) == 0 ? 8'hff : 8'h07);
        idle = idle + 3;
      end else begin
        it = mk(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
        send_item(it);
        idle = idle + 1;
      end
    end
    send_item(mk(1'b0, 8'h00, 1'b1));
    in_valid <= 1'b0;

    while (lookup_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    stim_done = 1'b1;
    $display("keys answered: %0d (present %0d, not found %0d, inserted %0d, full %0d)",
             results_seen, present_seen, notfound_seen, inserted_seen, full_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/dat_pkg.sv
rtl/dat_store.sv
rtl/dat_ctrl.sv
rtl/dat_clear.sv
rtl/double_array_trie_lookup_insert_top.sv
rtl/dat_checker.sv
dv/double_array_trie_lookup_insert_top_tb.sv
